// ===== rtl/sprite_quad_vertex_setup_macros.svh =====
// Assertion macros for the sprite quad vertex setup checker.
// Include this header by its bare file name; it depends on nothing else.
`ifndef SPRITE_QUAD_VERTEX_SETUP_MACROS_SVH
`define SPRITE_QUAD_VERTEX_SETUP_MACROS_SVH

// Concurrent assertion that is switched off while the synchronous reset is low.
`define SQVS_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Concurrent assertion that also checks across reset.
`define SQVS_ASSERT_NORST(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/sqvs_pkg.sv =====
// Package for the sprite quad vertex setup block: widths, codes, the job type
// passed from front to back, and the constant function that builds the sine table.
package sqvs_pkg;

    // Angle and sine table geometry.
    localparam int ANGLE_BITS = 12;
    localparam int QUARTER    = 1 << (ANGLE_BITS - 2);
    localparam int IDX_W      = ANGLE_BITS - 1;
    localparam int ROM_DEPTH  = QUARTER + 1;
    localparam int SIN_MAG_W  = 15;
    localparam int TRIG_W     = 16;

    // Field widths.
    localparam int POS_W     = 16;
    localparam int SCALE_W   = 16;
    localparam int SRC_W     = 12;
    localparam int EDGE_W    = SRC_W + 1;
    localparam int TEX_W     = 13;
    localparam int COORD_W   = 16;
    localparam int CORNER_W  = 2;

    // Offset and rotation datapath widths.
    localparam int OFS0_W     = 33;
    localparam int OFS_W      = OFS0_W + 1;
    localparam int PROD_W     = OFS_W + TRIG_W;
    localparam int ROT_W      = PROD_W + 1;
    localparam int FRAC_SHIFT = 22;
    localparam int DELTA_W    = ROT_W - FRAC_SHIFT;
    localparam int SUM_W      = DELTA_W + 1;

    localparam logic signed [SUM_W-1:0] POS_MAX = SUM_W'((1 << (POS_W - 1)) - 1);
    localparam logic signed [SUM_W-1:0] POS_MIN = -(SUM_W'(1 << (POS_W - 1)));

    // Texture coordinate divider.
    localparam int NUM_W           = 28;
    localparam int QUO_W           = COORD_W;
    localparam int REM_W           = TEX_W;
    localparam int DIGITS_PER_STEP = 4;
    localparam int DIV_STEPS       = QUO_W / DIGITS_PER_STEP;
    localparam int DIV_CNT_W       = $clog2(DIV_STEPS);
    localparam int LANES           = 4;

    // Queue between front and back.
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Configuration register indexes.
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_TEX_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_TEX_HEIGHT = 1'b1;

    // Corner codes.
    localparam logic [CORNER_W-1:0] CORNER_TL = 2'd0;
    localparam logic [CORNER_W-1:0] CORNER_BR = 2'd3;

    // Sine table constants, Q2.30 and Q1.14.
    localparam longint unsigned ONE_Q30  = 64'd1 << 30;
    localparam longint unsigned PI_Q30   = 64'd3373259426;
    localparam longint unsigned UNIT_Q14 = 64'd16384;

    typedef logic [SIN_MAG_W-1:0] t_sine_rom [ROM_DEPTH];

    // One sprite after setup, ready for the back end.
    typedef struct packed {
        logic signed [POS_W-1:0]  pos_x;
        logic signed [POS_W-1:0]  pos_y;
        logic signed [OFS0_W-1:0] ox;
        logic signed [OFS0_W-1:0] oy;
        logic signed [OFS0_W-1:0] wx;
        logic signed [OFS0_W-1:0] hy;
        logic signed [TRIG_W-1:0] sn;
        logic signed [TRIG_W-1:0] cs;
        logic [EDGE_W-1:0]        u_lo;
        logic [EDGE_W-1:0]        u_hi;
        logic [EDGE_W-1:0]        v_lo;
        logic [EDGE_W-1:0]        v_hi;
    } t_job;

    // First quadrant sine, degree-9 Taylor series in Q2.30, rounded to Q1.14.
    function automatic logic [SIN_MAG_W-1:0] sine_quadrant(input longint unsigned r);
        longint unsigned x;
        longint unsigned x2;
        longint unsigned t;
        longint unsigned s;
        longint unsigned q;
        x  = (r * PI_Q30 + QUARTER) / (2 * QUARTER);
        x2 = (x * x) >> 30;
        t  = ONE_Q30 - x2 / 72;
        t  = ONE_Q30 - ((x2 * t) >> 30) / 42;
        t  = ONE_Q30 - ((x2 * t) >> 30) / 20;
        t  = ONE_Q30 - ((x2 * t) >> 30) / 6;
        s  = (x * t) >> 30;
        q  = (s + (64'd1 << 15)) >> 16;
        if (q > UNIT_Q14) begin
            q = UNIT_Q14;
        end
        return q[SIN_MAG_W-1:0];
    endfunction

    // Whole quadrant table, built at elaboration.
    function automatic t_sine_rom build_sine_rom();
        t_sine_rom rom;
        for (int i = 0; i < ROM_DEPTH; i++) begin
            rom[i] = sine_quadrant(64'(i));
        end
        return rom;
    endfunction

endpackage

// ===== rtl/sqvs_queue.sv =====
// Two-entry job queue between the front and back ends of the vertex setup.
// Depends on sqvs_pkg for the job type and depth.
module sqvs_queue import sqvs_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    output logic o_full,
    input  logic i_pop,
    output t_job o_job,
    output logic o_empty
);

    t_job              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wptr;
    logic [QPTR_W-1:0] r_rptr;
    logic [QCNT_W-1:0] r_count;
    logic              w_do_push;
    logic              w_do_pop;

    assign o_full    = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_empty   = (r_count == '0);
    assign w_do_push = i_push && !o_full;
    assign w_do_pop  = i_pop && !o_empty;
    assign o_job     = r_mem[r_rptr];

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (w_do_push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (w_do_pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
            if (w_do_push && !w_do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (w_do_pop && !w_do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_mem[r_wptr] <= i_job;
        end
    end

endmodule

// ===== rtl/sqvs_front.sv =====
// Front end of the vertex setup: takes a sprite beat, looks up sine and cosine,
// forms the scaled corner offsets and texture edges. Depends on sqvs_pkg.
module sqvs_front import sqvs_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     push,
    output logic                     full,
    input  logic signed [POS_W-1:0]  i_pos_x,
    input  logic signed [POS_W-1:0]  i_pos_y,
    input  logic signed [POS_W-1:0]  i_origin_x,
    input  logic signed [POS_W-1:0]  i_origin_y,
    input  logic [ANGLE_BITS-1:0]    i_angle,
    input  logic [SCALE_W-1:0]       i_scale_x,
    input  logic [SCALE_W-1:0]       i_scale_y,
    input  logic [SRC_W-1:0]         i_src_x,
    input  logic [SRC_W-1:0]         i_src_y,
    input  logic [SRC_W-1:0]         i_src_w,
    input  logic [SRC_W-1:0]         i_src_h,
    input  logic                     i_q_full,
    output logic                     o_q_push,
    output t_job                     o_q_job
);

    localparam t_sine_rom SINE_ROM = build_sine_rom();

    logic                     r_valid;
    logic [SIN_MAG_W-1:0]     r_sin_mag;
    logic [SIN_MAG_W-1:0]     r_cos_mag;
    logic                     r_sin_neg;
    logic                     r_cos_neg;
    logic signed [POS_W-1:0]  r_pos_x;
    logic signed [POS_W-1:0]  r_pos_y;
    logic signed [OFS0_W-1:0] r_ox;
    logic signed [OFS0_W-1:0] r_oy;
    logic signed [OFS0_W-1:0] r_wx;
    logic signed [OFS0_W-1:0] r_hy;
    logic [EDGE_W-1:0]        r_u_lo;
    logic [EDGE_W-1:0]        r_u_hi;
    logic [EDGE_W-1:0]        r_v_lo;
    logic [EDGE_W-1:0]        r_v_hi;

    logic                     w_accept;
    logic [ANGLE_BITS-1:0]    w_ang_c;
    logic [IDX_W-1:0]         w_idx_s;
    logic [IDX_W-1:0]         w_idx_c;
    logic signed [POS_W:0]    w_nogx;
    logic signed [POS_W:0]    w_nogy;
    logic signed [OFS_W-1:0]  w_ox_full;
    logic signed [OFS_W-1:0]  w_oy_full;
    logic [SRC_W+SCALE_W-1:0] w_wx_prod;
    logic [SRC_W+SCALE_W-1:0] w_hy_prod;

    // Fold an angle into the first quadrant table index.
    function automatic logic [IDX_W-1:0] quad_index(input logic [ANGLE_BITS-1:0] a);
        logic [IDX_W-1:0] r;
        r = {1'b0, a[ANGLE_BITS-3:0]};
        return a[ANGLE_BITS-2] ? (IDX_W'(QUARTER) - r) : r;
    endfunction

    assign full     = r_valid && i_q_full;
    assign w_accept = push && !full;
    assign o_q_push = r_valid && !i_q_full;

    // Table addresses; cosine is the sine a quarter turn later.
    assign w_ang_c = i_angle + ANGLE_BITS'(QUARTER);
    assign w_idx_s = quad_index(i_angle);
    assign w_idx_c = quad_index(w_ang_c);

    // Scaled offsets: negated origin times scale, source size times scale in Q.12.
    assign w_nogx    = -$signed({i_origin_x[POS_W-1], i_origin_x});
    assign w_nogy    = -$signed({i_origin_y[POS_W-1], i_origin_y});
    assign w_ox_full = w_nogx * $signed({1'b0, i_scale_x});
    assign w_oy_full = w_nogy * $signed({1'b0, i_scale_y});
    assign w_wx_prod = i_src_w * i_scale_x;
    assign w_hy_prod = i_src_h * i_scale_y;

    // Stage valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_accept) begin
            r_valid <= 1'b1;
        end else if (!i_q_full) begin
            r_valid <= 1'b0;
        end
    end

    // Stage payload, including the registered sine table reads.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_sin_mag <= SINE_ROM[w_idx_s];
            r_cos_mag <= SINE_ROM[w_idx_c];
            r_sin_neg <= i_angle[ANGLE_BITS-1];
            r_cos_neg <= w_ang_c[ANGLE_BITS-1];
            r_pos_x   <= i_pos_x;
            r_pos_y   <= i_pos_y;
            r_ox      <= OFS0_W'(w_ox_full);
            r_oy      <= OFS0_W'(w_oy_full);
            r_wx      <= $signed({1'b0, w_wx_prod, 4'b0});
            r_hy      <= $signed({1'b0, w_hy_prod, 4'b0});
            r_u_lo    <= {1'b0, i_src_x};
            r_u_hi    <= {1'b0, i_src_x} + {1'b0, i_src_w};
            r_v_lo    <= {1'b0, i_src_y};
            r_v_hi    <= {1'b0, i_src_y} + {1'b0, i_src_h};
        end
    end

    // Signed sine and cosine and the job handed to the queue.
    always_comb begin
        o_q_job.pos_x = r_pos_x;
        o_q_job.pos_y = r_pos_y;
        o_q_job.ox    = r_ox;
        o_q_job.oy    = r_oy;
        o_q_job.wx    = r_wx;
        o_q_job.hy    = r_hy;
        o_q_job.sn    = r_sin_neg ? -$signed({1'b0, r_sin_mag}) : $signed({1'b0, r_sin_mag});
        o_q_job.cs    = r_cos_neg ? -$signed({1'b0, r_cos_mag}) : $signed({1'b0, r_cos_mag});
        o_q_job.u_lo  = r_u_lo;
        o_q_job.u_hi  = r_u_hi;
        o_q_job.v_lo  = r_v_lo;
        o_q_job.v_hi  = r_v_hi;
    end

endmodule

// ===== rtl/sqvs_back.sv =====
// Back end of the vertex setup: texture coordinate dividers, corner issue and
// the rotate, round and saturate pipeline with the result register. Depends on sqvs_pkg.
module sqvs_back import sqvs_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_job                     i_q_job,
    input  logic                     i_q_empty,
    output logic                     o_q_pop,
    input  logic [TEX_W-1:0]         i_tex_w,
    input  logic [TEX_W-1:0]         i_tex_h,
    output logic                     empty,
    input  logic                     pop,
    output logic [CORNER_W-1:0]      o_corner,
    output logic signed [POS_W-1:0]  o_vert_x,
    output logic signed [POS_W-1:0]  o_vert_y,
    output logic [COORD_W-1:0]       o_tex_u,
    output logic [COORD_W-1:0]       o_tex_v,
    output logic                     o_last_corner
);

    typedef enum logic [1:0] {
        DV_IDLE,
        DV_RUN,
        DV_DONE
    } t_dv_state;

    localparam logic signed [ROT_W-1:0] ROUND_HALF = ROT_W'(1) << (FRAC_SHIFT - 1);

    // Divider stage.
    t_dv_state            r_dv_state;
    logic [DIV_CNT_W-1:0] r_dv_cnt;
    t_job                 r_dv_job;
    logic [REM_W-1:0]     r_rem [LANES];
    logic [QUO_W-1:0]     r_num [LANES];
    logic [QUO_W-1:0]     r_quo [LANES];
    logic                 r_ovf [LANES];

    logic [EDGE_W-1:0]    w_edge    [LANES];
    logic [TEX_W-1:0]     w_div     [LANES];
    logic [NUM_W-1:0]     w_numer   [LANES];
    logic [REM_W-1:0]     w_rem_nx  [LANES];
    logic [QUO_W-1:0]     w_num_nx  [LANES];
    logic [QUO_W-1:0]     w_quo_nx  [LANES];
    logic [COORD_W-1:0]   w_coord   [LANES];

    // Issue stage.
    logic                 r_is_valid;
    logic [CORNER_W-1:0]  r_k;
    t_job                 r_is_job;
    logic [COORD_W-1:0]   r_is_u_lo;
    logic [COORD_W-1:0]   r_is_u_hi;
    logic [COORD_W-1:0]   r_is_v_lo;
    logic [COORD_W-1:0]   r_is_v_hi;

    // Corner offset stage.
    logic                     r_s1_valid;
    logic [CORNER_W-1:0]      r_s1_corner;
    logic signed [OFS_W-1:0]  r_s1_cx;
    logic signed [OFS_W-1:0]  r_s1_cy;
    logic signed [TRIG_W-1:0] r_s1_sn;
    logic signed [TRIG_W-1:0] r_s1_cs;
    logic signed [POS_W-1:0]  r_s1_px;
    logic signed [POS_W-1:0]  r_s1_py;
    logic [COORD_W-1:0]       r_s1_u;
    logic [COORD_W-1:0]       r_s1_v;

    // Product stage.
    logic                     r_s2_valid;
    logic [CORNER_W-1:0]      r_s2_corner;
    logic signed [PROD_W-1:0] r_s2_xc;
    logic signed [PROD_W-1:0] r_s2_ys;
    logic signed [PROD_W-1:0] r_s2_xs;
    logic signed [PROD_W-1:0] r_s2_yc;
    logic signed [POS_W-1:0]  r_s2_px;
    logic signed [POS_W-1:0]  r_s2_py;
    logic [COORD_W-1:0]       r_s2_u;
    logic [COORD_W-1:0]       r_s2_v;

    // Result register.
    logic                     r_out_valid;
    logic [CORNER_W-1:0]      r_out_corner;
    logic signed [POS_W-1:0]  r_out_x;
    logic signed [POS_W-1:0]  r_out_y;
    logic [COORD_W-1:0]       r_out_u;
    logic [COORD_W-1:0]       r_out_v;
    logic                     r_out_last;

    logic                      w_adv;
    logic                      w_handoff;
    logic                      w_load_dv;
    logic signed [ROT_W-1:0]   w_rx;
    logic signed [ROT_W-1:0]   w_ry;
    logic signed [ROT_W-1:0]   w_rx_r;
    logic signed [ROT_W-1:0]   w_ry_r;
    logic signed [DELTA_W-1:0] w_dx;
    logic signed [DELTA_W-1:0] w_dy;
    logic signed [SUM_W-1:0]   w_sx;
    logic signed [SUM_W-1:0]   w_sy;

    function automatic logic [POS_W-1:0] sat_pos(input logic signed [SUM_W-1:0] v);
        logic [POS_W-1:0] res;
        if (v > POS_MAX) begin
            res = POS_W'(POS_MAX);
        end else if (v < POS_MIN) begin
            res = POS_W'(POS_MIN);
        end else begin
            res = v[POS_W-1:0];
        end
        return res;
    endfunction

    // The pipeline from issue to result moves only when the result slot frees.
    assign w_adv     = !r_out_valid || pop;
    assign w_handoff = (r_dv_state == DV_DONE) &&
                       (!r_is_valid || (w_adv && (r_k == CORNER_BR)));
    assign w_load_dv = !i_q_empty && ((r_dv_state == DV_IDLE) || w_handoff);
    assign o_q_pop   = w_load_dv;

    // Lane operands: left and right u against width, top and bottom v against height.
    assign w_edge[0] = i_q_job.u_lo;
    assign w_edge[1] = i_q_job.u_hi;
    assign w_edge[2] = i_q_job.v_lo;
    assign w_edge[3] = i_q_job.v_hi;
    assign w_div[0]  = i_tex_w;
    assign w_div[1]  = i_tex_w;
    assign w_div[2]  = i_tex_h;
    assign w_div[3]  = i_tex_h;

    for (genvar l = 0; l < LANES; l++) begin : g_lane
        // Numerator is edge * 32768 plus half the divisor, for rounding half up.
        assign w_numer[l] = NUM_W'({w_edge[l], 15'b0}) + NUM_W'(w_div[l] >> 1);
        assign w_coord[l] = r_ovf[l] ? {COORD_W{1'b1}} : r_quo[l];

        // Four restoring division steps per cycle.
        always_comb begin
            logic [REM_W:0]   sh;
            logic [REM_W-1:0] rem;
            logic [QUO_W-1:0] num;
            logic [QUO_W-1:0] quo;
            rem = r_rem[l];
            num = r_num[l];
            quo = r_quo[l];
            for (int j = 0; j < DIGITS_PER_STEP; j++) begin
                sh  = {rem, num[QUO_W-1]};
                num = num << 1;
                if (sh >= {1'b0, w_div[l]}) begin
                    rem = REM_W'(sh - {1'b0, w_div[l]});
                    quo = {quo[QUO_W-2:0], 1'b1};
                end else begin
                    rem = sh[REM_W-1:0];
                    quo = {quo[QUO_W-2:0], 1'b0};
                end
            end
            w_rem_nx[l] = rem;
            w_num_nx[l] = num;
            w_quo_nx[l] = quo;
        end

        // Lane registers; a quotient of 2^16 or more is flagged at load.
        always_ff @(posedge i_clk) begin
            if (w_load_dv) begin
                r_ovf[l] <= ({1'b0, w_numer[l][NUM_W-1:QUO_W]} >= w_div[l]);
                r_rem[l] <= {1'b0, w_numer[l][NUM_W-1:QUO_W]};
                r_num[l] <= w_numer[l][QUO_W-1:0];
                r_quo[l] <= '0;
            end else if (r_dv_state == DV_RUN) begin
                r_rem[l] <= w_rem_nx[l];
                r_num[l] <= w_num_nx[l];
                r_quo[l] <= w_quo_nx[l];
            end
        end
    end

    // Divider stage control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv_state <= DV_IDLE;
            r_dv_cnt   <= '0;
        end else if (w_load_dv) begin
            r_dv_state <= DV_RUN;
            r_dv_cnt   <= '0;
        end else begin
            unique case (r_dv_state)
                DV_IDLE: begin
                    r_dv_state <= DV_IDLE;
                end
                DV_RUN: begin
                    r_dv_cnt <= r_dv_cnt + 1'b1;
                    if (r_dv_cnt == DIV_CNT_W'(DIV_STEPS - 1)) begin
                        r_dv_state <= DV_DONE;
                    end
                end
                DV_DONE: begin
                    if (w_handoff) begin
                        r_dv_state <= DV_IDLE;
                    end
                end
                default: begin
                    r_dv_state <= DV_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load_dv) begin
            r_dv_job <= i_q_job;
        end
    end

    // Issue stage: one corner per advance, four per sprite.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_is_valid <= 1'b0;
            r_k        <= CORNER_TL;
        end else if (w_handoff) begin
            r_is_valid <= 1'b1;
            r_k        <= CORNER_TL;
        end else if (w_adv && r_is_valid) begin
            r_k <= r_k + 1'b1;
            if (r_k == CORNER_BR) begin
                r_is_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_handoff) begin
            r_is_job  <= r_dv_job;
            r_is_u_lo <= w_coord[0];
            r_is_u_hi <= w_coord[1];
            r_is_v_lo <= w_coord[2];
            r_is_v_hi <= w_coord[3];
        end
    end

    // Pipeline valids.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_s1_valid  <= r_is_valid;
            r_s2_valid  <= r_s1_valid;
            r_out_valid <= r_s2_valid;
        end
    end

    // Corner offsets: add the size on the right and bottom edges.
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s1_corner <= r_k;
            r_s1_cx     <= OFS_W'(r_is_job.ox) + (r_k[0] ? OFS_W'(r_is_job.wx) : '0);
            r_s1_cy     <= OFS_W'(r_is_job.oy) + (r_k[1] ? OFS_W'(r_is_job.hy) : '0);
            r_s1_sn     <= r_is_job.sn;
            r_s1_cs     <= r_is_job.cs;
            r_s1_px     <= r_is_job.pos_x;
            r_s1_py     <= r_is_job.pos_y;
            r_s1_u      <= r_k[0] ? r_is_u_hi : r_is_u_lo;
            r_s1_v      <= r_k[1] ? r_is_v_hi : r_is_v_lo;
        end
    end

    // Rotation products.
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s2_corner <= r_s1_corner;
            r_s2_xc     <= r_s1_cx * r_s1_cs;
            r_s2_ys     <= r_s1_cy * r_s1_sn;
            r_s2_xs     <= r_s1_cx * r_s1_sn;
            r_s2_yc     <= r_s1_cy * r_s1_cs;
            r_s2_px     <= r_s1_px;
            r_s2_py     <= r_s1_py;
            r_s2_u      <= r_s1_u;
            r_s2_v      <= r_s1_v;
        end
    end

    // Round half up to Q.4, add the position and saturate.
    assign w_rx   = ROT_W'(r_s2_xc) - ROT_W'(r_s2_ys);
    assign w_ry   = ROT_W'(r_s2_xs) + ROT_W'(r_s2_yc);
    assign w_rx_r = w_rx + ROUND_HALF;
    assign w_ry_r = w_ry + ROUND_HALF;
    assign w_dx   = w_rx_r[ROT_W-1:FRAC_SHIFT];
    assign w_dy   = w_ry_r[ROT_W-1:FRAC_SHIFT];
    assign w_sx   = SUM_W'(w_dx) + SUM_W'(r_s2_px);
    assign w_sy   = SUM_W'(w_dy) + SUM_W'(r_s2_py);

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out_corner <= r_s2_corner;
            r_out_x      <= sat_pos(w_sx);
            r_out_y      <= sat_pos(w_sy);
            r_out_u      <= r_s2_u;
            r_out_v      <= r_s2_v;
            r_out_last   <= (r_s2_corner == CORNER_BR);
        end
    end

    assign empty         = !r_out_valid;
    assign o_corner      = r_out_corner;
    assign o_vert_x      = r_out_x;
    assign o_vert_y      = r_out_y;
    assign o_tex_u       = r_out_u;
    assign o_tex_v       = r_out_v;
    assign o_last_corner = r_out_last;

endmodule

// ===== rtl/sprite_quad_vertex_setup.sv =====
// Sprite quad vertex setup: takes one sprite per push beat and returns its four corner
// vertices (top-left, top-right, bottom-left, bottom-right) as four pop beats, one per
// cycle within a sprite while pop is held. The four texture coordinate dividers set the
// sustained rate, as each loads its operands and then retires the quotient four bits at a
// time; the single result port alone would be faster, so under a steady stream a pop
// between two sprites can find no beat. Sine and cosine come from a 1025-entry
// quarter-wave table read once per sprite at two addresses. The texture size registers
// must be written by the user only while idle; nothing in the block enforces this. No
// clearing pass is needed after reset. Depends on sqvs_pkg, sqvs_front, sqvs_queue and
// sqvs_back.
module sprite_quad_vertex_setup import sqvs_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     push,
    output logic                     full,
    input  logic signed [POS_W-1:0]  i_pos_x,
    input  logic signed [POS_W-1:0]  i_pos_y,
    input  logic signed [POS_W-1:0]  i_origin_x,
    input  logic signed [POS_W-1:0]  i_origin_y,
    input  logic [ANGLE_BITS-1:0]    i_angle,
    input  logic [SCALE_W-1:0]       i_scale_x,
    input  logic [SCALE_W-1:0]       i_scale_y,
    input  logic [SRC_W-1:0]         i_src_x,
    input  logic [SRC_W-1:0]         i_src_y,
    input  logic [SRC_W-1:0]         i_src_w,
    input  logic [SRC_W-1:0]         i_src_h,
    output logic                     empty,
    input  logic                     pop,
    output logic [CORNER_W-1:0]      o_corner,
    output logic signed [POS_W-1:0]  o_vert_x,
    output logic signed [POS_W-1:0]  o_vert_y,
    output logic [COORD_W-1:0]       o_tex_u,
    output logic [COORD_W-1:0]       o_tex_v,
    output logic                     o_last_corner,
    input  logic                     i_cfg_we,
    input  logic [CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [TEX_W-1:0]         i_cfg_data
);

    logic [TEX_W-1:0] r_tex_width;
    logic [TEX_W-1:0] r_tex_height;
    logic [TEX_W-1:0] w_tex_w;
    logic [TEX_W-1:0] w_tex_h;
    logic             w_q_push;
    logic             w_q_full;
    logic             w_q_pop;
    logic             w_q_empty;
    t_job             w_front_job;
    t_job             w_back_job;

    // Texture size registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tex_width  <= TEX_W'(1);
            r_tex_height <= TEX_W'(1);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_TEX_WIDTH:  r_tex_width  <= i_cfg_data;
                REG_TEX_HEIGHT: r_tex_height <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // A size of zero divides as one.
    assign w_tex_w = (r_tex_width  == '0) ? TEX_W'(1) : r_tex_width;
    assign w_tex_h = (r_tex_height == '0) ? TEX_W'(1) : r_tex_height;

    sqvs_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .push       (push),
        .full       (full),
        .i_pos_x    (i_pos_x),
        .i_pos_y    (i_pos_y),
        .i_origin_x (i_origin_x),
        .i_origin_y (i_origin_y),
        .i_angle    (i_angle),
        .i_scale_x  (i_scale_x),
        .i_scale_y  (i_scale_y),
        .i_src_x    (i_src_x),
        .i_src_y    (i_src_y),
        .i_src_w    (i_src_w),
        .i_src_h    (i_src_h),
        .i_q_full   (w_q_full),
        .o_q_push   (w_q_push),
        .o_q_job    (w_front_job)
    );

    sqvs_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_q_push),
        .i_job   (w_front_job),
        .o_full  (w_q_full),
        .i_pop   (w_q_pop),
        .o_job   (w_back_job),
        .o_empty (w_q_empty)
    );

    sqvs_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_job       (w_back_job),
        .i_q_empty     (w_q_empty),
        .o_q_pop       (w_q_pop),
        .i_tex_w       (w_tex_w),
        .i_tex_h       (w_tex_h),
        .empty         (empty),
        .pop           (pop),
        .o_corner      (o_corner),
        .o_vert_x      (o_vert_x),
        .o_vert_y      (o_vert_y),
        .o_tex_u       (o_tex_u),
        .o_tex_v       (o_tex_v),
        .o_last_corner (o_last_corner)
    );

endmodule

// ===== rtl/sqvs_checker.sv =====
// Port-level checker for the sprite quad vertex setup, bound to the top level.
// Depends on sqvs_pkg and the assertion macros header.
`include "sprite_quad_vertex_setup_macros.svh"

module sqvs_checker import sqvs_pkg::*; (
    input logic                     i_clk,
    input logic                     i_rst_n,
    input logic                     full,
    input logic                     empty,
    input logic                     pop,
    input logic [CORNER_W-1:0]      o_corner,
    input logic signed [POS_W-1:0]  o_vert_x,
    input logic signed [POS_W-1:0]  o_vert_y,
    input logic [COORD_W-1:0]       o_tex_u,
    input logic [COORD_W-1:0]       o_tex_v,
    input logic                     o_last_corner
);

    // The last flag marks the bottom-right corner and nothing else.
    `SQVS_ASSERT(a_last_is_br, i_clk, i_rst_n, !empty |-> (o_last_corner == (o_corner == CORNER_BR)), "last_corner does not match corner")

    // Within a sprite the next corner is ready right after a beat is taken.
    `SQVS_ASSERT(a_corner_follows, i_clk, i_rst_n, (!empty && pop && o_corner != CORNER_BR) |=> (!empty && o_corner == $past(o_corner) + 2'd1), "corner sequence broken")

    // A waiting result beat holds its payload.
    `SQVS_ASSERT(a_result_holds, i_clk, i_rst_n, (!empty && !pop) |=> (!empty && $stable(o_corner) && $stable(o_vert_x) && $stable(o_vert_y) && $stable(o_tex_u) && $stable(o_tex_v)), "waiting result changed")

    // Reset leaves both sides open and empty.
    `SQVS_ASSERT_NORST(a_reset_clears, i_clk, !i_rst_n |=> (empty && !full), "reset did not clear the block")

endmodule

bind sprite_quad_vertex_setup sqvs_checker u_checker (.*);
